/* rtl/core/dhct_pkg.sv */
// Shared types, constants and helpers of the double-hash count table.
package dhct_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int SLOT_W = $clog2(TABLE_DEPTH);
  localparam int SIZE_W = SLOT_W + 1;
  localparam int ID_CHARS = 22;
  localparam int IDX_W = $clog2(ID_CHARS + 1);
  localparam int KEY_W = 176;
  localparam int SCORE_W = 7;
  localparam int COUNT_W = 32;
  localparam int RED_W = 38;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [RED_W-1:0] HASH_MOD = RED_W'(64'd1000000009);
  localparam logic [5:0] HASH_BASE = 6'd52;
  localparam logic [31:0] GOLDEN_Q32 = 32'd2654435769;
  localparam logic signed [8:0] CHAR_BIAS = 9'sd96;
  localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(3);
  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(TABLE_DEPTH);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_CHAR,
    F_SUM,
    F_RED,
    F_FRAC,
    F_PROBE,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_ISSUE,
    B_CHECK
  } back_state_t;

  typedef struct packed {
    logic                  is_find;
    logic [KEY_W-1:0]      key;
    logic [KEY_W-1:0]      item;
    logic [SCORE_W-1:0]    score;
    logic [COUNT_W-1:0]    start_count;
    logic [SLOT_W-1:0]     h1;
    logic [SLOT_W-1:0]     h2;
  } job_t;

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [COUNT_W-1:0]    count;
    logic [KEY_W-1:0]      best;
    logic [SCORE_W-1:0]    score;
  } rec_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s < SIZE_MIN) r = SIZE_MIN;
    if (s > SIZE_MAX) r = SIZE_MAX;
    return r;
  endfunction

  function automatic logic [RED_W-1:0] red_step(input logic [RED_W-1:0] x,
                                                input int unsigned k);
    logic [RED_W-1:0] m;
    m = HASH_MOD << k;
    return (x >= m) ? x - m : x;
  endfunction

endpackage

/* rtl/core/dhct_if.sv */
// Request and response channel interfaces of the double-hash count table.
interface dhct_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] key_word_a;
  logic [63:0] key_word_b;
  logic [47:0] key_word_c;
  logic [63:0] item_word_a;
  logic [63:0] item_word_b;
  logic [47:0] item_word_c;
  logic [6:0]  item_score;
  logic [31:0] start_count;

  modport source (output valid, kind, key_word_a, key_word_b, key_word_c, item_word_a,
                  item_word_b, item_word_c, item_score, start_count, input ready);
  modport sink (input valid, kind, key_word_a, key_word_b, key_word_c, item_word_a,
                item_word_b, item_word_c, item_score, start_count, output ready);
endinterface

interface dhct_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] slot;
  logic [12:0] filled_slots;

  modport source (output valid, status, slot, filled_slots, input ready);
  modport sink (input valid, status, slot, filled_slots, output ready);
endinterface

/* rtl/core/double_hash_count_table_top.sv */
// Top level of the double-hash count table: config register, front end, queue, back end.
//
// After reset the back end clears the occupancy flag of every slot before it starts a
// probe walk; requests taken meanwhile are hashed and wait in the queue. Keys hold up to
// 22 characters, and for each one the front end does one multiply, one add and four
// two-bit remainder steps. The back end then issues each probe (B_ISSUE) to the slot
// memory's registered read port and checks the word it returns (B_CHECK). A two-job
// queue lets the front end hash the next key while the back end is probing.
module double_hash_count_table_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [12:0]          cfg_wdata,
  dhct_in_if.sink              req,
  dhct_out_if.source           rsp
);
  import dhct_pkg::*;

  logic [SIZE_W-1:0] table_size;
  logic [SIZE_W-1:0] size;
  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_data, pop_data;

  always_ff @(posedge clk) begin
    if (rst) table_size <= SIZE_RESET;
    else if (cfg_we) table_size <= cfg_wdata;
  end

  assign size = eff_size(table_size);

  dhct_front u_front (
    .clk(clk), .rst(rst), .size(size), .req(req),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
  );

  dhct_queue u_queue (
    .clk(clk), .rst(rst),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
  );

  dhct_back u_back (
    .clk(clk), .rst(rst), .size(size),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data), .rsp(rsp)
  );

endmodule

/* rtl/core/dhct_front.sv */
// Front end: accepts a request, hashes the key and derives the probe start and step.
module dhct_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [dhct_pkg::SIZE_W-1:0] size,
  dhct_in_if.sink               req,
  output logic                  push_valid,
  input  logic                  push_ready,
  output dhct_pkg::job_t        push_data
);
  import dhct_pkg::*;

  front_state_t state, state_next;
  job_t job;
  logic [IDX_W-1:0] ch_idx;
  logic signed [30:0] h;
  logic [29:0] pw;
  logic signed [38:0] prod;
  logic [RED_W-1:0] pwp;
  logic [RED_W-1:0] red;
  logic neg;
  logic [1:0] step;
  logic [31:0] frac;

  logic [KEY_W-1:0] raw_key, norm_key;
  logic [7:0] key_bytes [ID_CHARS];
  logic [7:0] ch;
  logic key_end;
  logic alive;
  logic signed [8:0] ch_s;
  logic signed [30:0] pw_s;
  logic signed [39:0] prod_full;
  logic signed [39:0] sum;
  logic [39:0] sum_mag;
  logic [RED_W-1:0] red_a, red_b, pwp_a, pwp_b;
  logic [29:0] kmag;
  logic [61:0] kprod;
  logic [44:0] h1_full, h2_full;
  logic load, take_char;

  assign raw_key = {req.key_word_c, req.key_word_b, req.key_word_a};

  always_comb begin
    alive = 1'b1;
    norm_key = '0;
    for (int j = 0; j < ID_CHARS; j++) begin
      alive = alive & (raw_key[8*j +: 8] != 8'd0);
      if (alive) norm_key[8*j +: 8] = raw_key[8*j +: 8];
    end
  end

  always_comb begin
    for (int j = 0; j < ID_CHARS; j++) key_bytes[j] = job.key[8*j +: 8];
  end

  assign ch = (ch_idx < IDX_W'(ID_CHARS)) ? key_bytes[ch_idx] : 8'd0;
  assign key_end = (ch_idx == IDX_W'(ID_CHARS)) || (ch == 8'd0);
  assign ch_s = $signed({1'b0, ch}) - CHAR_BIAS;
  assign pw_s = $signed({1'b0, pw});
  assign prod_full = 40'(ch_s) * 40'(pw_s);
  assign sum = 40'(h) + 40'(prod);
  assign sum_mag = sum[39] ? 40'(-sum) : 40'(sum);
  assign red_a = red_step(red, 32'(7 - 2 * int'(step)));
  assign red_b = red_step(red_a, 32'(6 - 2 * int'(step)));
  assign pwp_a = red_step(pwp, 32'(7 - 2 * int'(step)));
  assign pwp_b = red_step(pwp_a, 32'(6 - 2 * int'(step)));
  assign kmag = h[30] ? 30'(-h) : 30'(h);
  assign kprod = 62'(kmag) * 62'(GOLDEN_Q32);
  assign h1_full = 45'(size) * 45'(frac);
  assign h2_full = 45'(size - SIZE_W'(2)) * 45'(frac);

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE:  if (req.valid) state_next = F_CHAR;
      F_CHAR:  state_next = key_end ? F_FRAC : F_SUM;
      F_SUM:   state_next = F_RED;
      F_RED:   if (step == 2'd3) state_next = F_CHAR;
      F_FRAC:  state_next = F_PROBE;
      F_PROBE: state_next = F_PUSH;
      F_PUSH:  if (push_ready) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == F_IDLE);
    push_valid = (state == F_PUSH);
    load = (state == F_IDLE) && req.valid;
    take_char = (state == F_CHAR) && !key_end;
  end

  assign push_data = job;

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job.is_find <= req.kind;
      job.key <= norm_key;
      job.item <= {req.item_word_c, req.item_word_b, req.item_word_a};
      job.score <= req.item_score;
      job.start_count <= req.start_count;
      ch_idx <= '0;
      h <= '0;
      pw <= 30'd1;
    end
    if (take_char) begin
      prod <= prod_full[38:0];
      pwp <= RED_W'(pw) * RED_W'(HASH_BASE);
    end
    if (state == F_SUM) begin
      neg <= sum[39];
      red <= sum_mag[RED_W-1:0];
      step <= '0;
    end
    if (state == F_RED) begin
      red <= red_b;
      pwp <= pwp_b;
      step <= step + 2'd1;
      if (step == 2'd3) begin
        h <= neg ? -$signed({1'b0, red_b[29:0]}) : $signed({1'b0, red_b[29:0]});
        pw <= pwp_b[29:0];
        ch_idx <= ch_idx + IDX_W'(1);
      end
    end
    if (state == F_FRAC) frac <= kprod[31:0];
    if (state == F_PROBE) begin
      job.h1 <= h1_full[32 +: SLOT_W];
      job.h2 <= h2_full[32 +: SLOT_W];
    end
  end

endmodule

/* rtl/core/dhct_queue.sv */
// Two-entry job queue between the hashing front end and the probing back end.
module dhct_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  dhct_pkg::job_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output dhct_pkg::job_t pop_data
);
  import dhct_pkg::*;

  job_t entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0] fill;
  logic do_push, do_pop;

  assign push_ready = (fill != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid = (fill != '0);
  assign pop_data = entries[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      fill <= fill + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

endmodule

/* rtl/core/dhct_back.sv */
// Back end: walks the probe sequence over the slot memory and delivers the result.
module dhct_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [dhct_pkg::SIZE_W-1:0] size,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  dhct_pkg::job_t        pop_data,
  dhct_out_if.source            rsp
);
  import dhct_pkg::*;

  back_state_t state, state_next;
  job_t job;
  logic [SLOT_W-1:0] pos;
  logic [SIZE_W-1:0] probe_cnt;
  logic [SLOT_W-1:0] clr;
  logic [SIZE_W-1:0] used_total;
  logic used_mem [TABLE_DEPTH];
  rec_t rec_mem [TABLE_DEPTH];
  logic used_q;
  rec_t rec_q;
  logic out_valid;
  status_t out_status;
  logic [SLOT_W-1:0] out_slot;
  logic [SIZE_W-1:0] out_filled;

  logic key_hit, last_probe, done, wr_en, start;
  status_t status_now;
  rec_t rec_wdata;
  logic [SIZE_W-1:0] pos_sum, pos_wrap;
  logic [SIZE_W-1:0] used_total_next;

  assign key_hit = used_q && (rec_q.key == job.key);
  assign last_probe = (probe_cnt == size - SIZE_W'(1));
  assign pos_sum = {1'b0, pos} + {1'b0, job.h2};
  assign pos_wrap = (pos_sum >= size) ? pos_sum - size : pos_sum;

  always_comb begin
    rec_wdata = rec_q;
    if (job.is_find) begin
      if (rec_q.count != '1) rec_wdata.count = rec_q.count + COUNT_W'(1);
      if (rec_q.score < job.score) begin
        rec_wdata.score = job.score;
        rec_wdata.best = job.item;
      end
    end else begin
      rec_wdata.key = job.key;
      rec_wdata.count = job.start_count;
      rec_wdata.best = job.item;
      rec_wdata.score = job.score;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_CLEAR: if (clr == '1) state_next = B_IDLE;
      B_IDLE:  if (start) state_next = B_ISSUE;
      B_ISSUE: state_next = B_CHECK;
      B_CHECK: state_next = done ? B_IDLE : B_ISSUE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    start = 1'b0;
    pop_ready = 1'b0;
    done = 1'b0;
    wr_en = 1'b0;
    status_now = ST_DONE;
    unique case (state)
      B_IDLE: begin
        pop_ready = !out_valid || rsp.ready;
        start = pop_valid && pop_ready;
      end
      B_CHECK: begin
        if (job.is_find) begin
          done = !used_q || key_hit || last_probe;
          wr_en = key_hit;
          status_now = key_hit ? ST_DONE : ST_NOT_FOUND;
        end else begin
          done = !used_q || last_probe;
          wr_en = !used_q;
          status_now = !used_q ? ST_DONE : ST_FULL;
        end
      end
      default: begin
        start = 1'b0;
      end
    endcase
  end

  assign used_total_next = used_total + SIZE_W'(wr_en && !job.is_find);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
      clr <= '0;
      used_total <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_CLEAR) clr <= clr + SLOT_W'(1);
      if (state == B_CHECK) used_total <= used_total_next;
      if (state == B_CHECK && done) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      job <= pop_data;
      pos <= pop_data.h1;
      probe_cnt <= '0;
    end
    if (state == B_CHECK && !done) begin
      pos <= pos_wrap[SLOT_W-1:0];
      probe_cnt <= probe_cnt + SIZE_W'(1);
    end
    if (state == B_CHECK && done) begin
      out_status <= status_now;
      out_slot <= (status_now == ST_DONE) ? pos : '0;
      out_filled <= used_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_CLEAR) used_mem[clr] <= 1'b0;
    else if (state == B_CHECK && wr_en) used_mem[pos] <= 1'b1;
    used_q <= used_mem[pos];
  end

  always_ff @(posedge clk) begin
    if (state == B_CHECK && wr_en) rec_mem[pos] <= rec_wdata;
    rec_q <= rec_mem[pos];
  end

  assign rsp.valid = out_valid;
  assign rsp.status = out_status;
  assign rsp.slot = out_slot;
  assign rsp.filled_slots = out_filled;

  assert property (@(posedge clk) disable iff (rst) used_total <= SIZE_W'(TABLE_DEPTH))
    else $error("occupied count beyond table depth");
  assert property (@(posedge clk) disable iff (rst) state == B_CLEAR |-> !out_valid)
    else $error("result shown during clearing pass");
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(state) == B_CHECK)
    else $error("result raised outside a probe check");
  assert property (@(posedge clk) disable iff (rst) state == B_CHECK |-> {1'b0, pos} < size)
    else $error("probe beyond table size");

endmodule
